// File: hdl/cau_pkg.sv
package cau_pkg;

    // default field width and fraction bits
    localparam int DEF_WIDTH     = 16;
    localparam int DEF_FRAC_BITS = 8;

    // opcode codes
    localparam int          OP_W   = 2;
    localparam logic [1:0]  OP_ADD = 2'd0;
    localparam logic [1:0]  OP_SUB = 2'd1;
    localparam logic [1:0]  OP_MUL = 2'd2;
    localparam logic [1:0]  OP_DIV = 2'd3;

    // output flag width in tuser
    localparam int FLAG_W = 2;

endpackage

// File: hdl/cau_divider.sv
module cau_divider #(
    parameter int WIDTH     = cau_pkg::DEF_WIDTH,
    parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  logic [2*WIDTH-1:0]   i_num_re,
    input  logic [2*WIDTH-1:0]   i_num_im,
    input  logic [2*WIDTH-1:0]   i_den,
    output logic [WIDTH+1:0]     o_quo_re,
    output logic [WIDTH+1:0]     o_quo_im,
    output logic                 o_ovf_re,
    output logic                 o_ovf_im
);

    localparam int PW = 2 * WIDTH;
    localparam int NQ = WIDTH + 2;
    localparam int DW = PW + FRAC_BITS + 1;
    localparam int HW = DW - NQ;
    localparam int CW = (HW > PW) ? HW : PW;

    logic [PW-1:0] w_num [0:1];

    logic [PW-1:0] r_rem [0:1][0:NQ];
    logic [NQ-1:0] r_low [0:1][0:NQ];
    logic [NQ-1:0] r_q   [0:1][0:NQ];
    logic          r_ovf [0:1][0:NQ];
    logic [PW-1:0] r_den [0:NQ];

    assign w_num[0] = i_num_re;
    assign w_num[1] = i_num_im;

    // shared divisor travels with the lanes
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_den[0] <= i_den;
            for (int k = 1; k <= NQ; k++) begin
                r_den[k] <= r_den[k-1];
            end
        end
    end

    genvar l, k;
    generate
        for (l = 0; l < 2; l++) begin : g_lane
            logic [DW-1:0] w_dvd;
            logic [HW-1:0] w_hi;
            logic          w_ovf;

            // dividend is the magnitude scaled by 2^(frac+1)
            assign w_dvd = {w_num[l], {(FRAC_BITS+1){1'b0}}};
            assign w_hi  = w_dvd[DW-1:NQ];
            assign w_ovf = CW'(w_hi) >= CW'(i_den);

            // first stage: overflow check and starting remainder
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_ovf[l][0] <= w_ovf;
                    r_rem[l][0] <= w_ovf ? '0 : PW'(w_hi);
                    r_low[l][0] <= w_dvd[NQ-1:0];
                    r_q[l][0]   <= '0;
                end
            end

            // one quotient bit per stage, restoring
            for (k = 1; k <= NQ; k++) begin : g_stage
                logic [PW:0] w_try;
                logic [PW:0] w_diff;
                logic        w_ge;

                assign w_try  = {r_rem[l][k-1], r_low[l][k-1][NQ-k]};
                assign w_ge   = w_try >= {1'b0, r_den[k-1]};
                assign w_diff = w_try - {1'b0, r_den[k-1]};

                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        r_rem[l][k] <= w_ge ? w_diff[PW-1:0] : w_try[PW-1:0];
                        r_low[l][k] <= r_low[l][k-1];
                        r_q[l][k]   <= {r_q[l][k-1][NQ-2:0], w_ge};
                        r_ovf[l][k] <= r_ovf[l][k-1];
                    end
                end
            end
        end
    endgenerate

    assign o_quo_re = r_q[0][NQ];
    assign o_quo_im = r_q[1][NQ];
    assign o_ovf_re = r_ovf[0][NQ];
    assign o_ovf_im = r_ovf[1][NQ];

endmodule

// File: hdl/complex_arithmetic_unit.sv
// channel   dir  tdata (low bit up)                 tuser (low bit up)
// s_axis    in   a_re, a_im, b_re, b_im             opcode
// m_axis    out  res_re, res_im, zero fill          saturated, div_by_zero
//
// one item per cycle while the output register is empty or taken; a result passes stages a, b, c,
// the restoring divider (one quotient bit per stage) with its side line, and the output register
// all stages advance together whenever the output register is empty or taken
// synchronous active-low reset clears the valid bits only
module complex_arithmetic_unit #(
    parameter int WIDTH     = cau_pkg::DEF_WIDTH,
    parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // a_re, a_im, b_re, b_im
    input  logic [((4*WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,
    // opcode
    input  logic [cau_pkg::OP_W-1:0]           i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // res_re, res_im
    output logic [((2*WIDTH+7)/8)*8-1:0]       o_m_axis_tdata,
    // saturated, div_by_zero
    output logic [cau_pkg::FLAG_W-1:0]         o_m_axis_tuser
);

    localparam int PW    = 2 * WIDTH;
    localparam int NQ    = WIDTH + 2;
    localparam int LAT   = NQ + 1;
    localparam int OUT_W = ((2*WIDTH+7)/8)*8;
    localparam logic [PW-1:0] HALF_LSB = PW'((64'd1 << FRAC_BITS) >> 1);
    localparam logic [PW-1:0] HALF_RNG = PW'(64'd1 << (WIDTH-1));

    logic w_ce;

    logic signed [WIDTH-1:0] w_ar, w_ai, w_br, w_bi;

    // stage a: products and add/subtract
    logic                        r_a_valid;
    logic [cau_pkg::OP_W-1:0]    r_a_op;
    logic signed [PW-1:0]        r_a_rr, r_a_ii, r_a_ri, r_a_ir, r_a_bb, r_a_cc;
    logic signed [WIDTH:0]       r_a_as_re, r_a_as_im;

    // stage b: signed sums and divisor
    logic                        r_b_valid;
    logic [cau_pkg::OP_W-1:0]    r_b_op;
    logic signed [PW:0]          r_b_re, r_b_im;
    logic [PW-1:0]               r_b_den;

    // stage c: sign and magnitude
    logic                        r_c_valid;
    logic [cau_pkg::OP_W-1:0]    r_c_op;
    logic                        r_c_neg_re, r_c_neg_im, r_c_dz;
    logic [PW-1:0]               r_c_mag_re, r_c_mag_im, r_c_den;

    // side line alongside the divider
    logic                        r_d_valid  [0:LAT-1];
    logic [cau_pkg::OP_W-1:0]    r_d_op     [0:LAT-1];
    logic                        r_d_dz     [0:LAT-1];
    logic                        r_d_neg_re [0:LAT-1];
    logic                        r_d_neg_im [0:LAT-1];
    logic [PW-1:0]               r_d_mag_re [0:LAT-1];
    logic [PW-1:0]               r_d_mag_im [0:LAT-1];

    logic [NQ-1:0]               w_quo_re, w_quo_im;
    logic                        w_ovf_re, w_ovf_im;

    // output register
    logic                        r_out_valid;
    logic [WIDTH-1:0]            r_res_re, r_res_im;
    logic                        r_sat, r_dz;

    logic [PW-1:0]               w_f_mag_re, w_f_mag_im;
    logic [WIDTH-1:0]            n_res_re, n_res_im;
    logic                        n_sat_re, n_sat_im;

    assign w_ce            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    assign w_ar = i_s_axis_tdata[WIDTH-1:0];
    assign w_ai = i_s_axis_tdata[2*WIDTH-1:WIDTH];
    assign w_br = i_s_axis_tdata[3*WIDTH-1:2*WIDTH];
    assign w_bi = i_s_axis_tdata[4*WIDTH-1:3*WIDTH];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < LAT; k++) begin
                r_d_valid[k] <= 1'b0;
            end
        end else if (w_ce) begin
            r_a_valid    <= i_s_axis_tvalid;
            r_b_valid    <= r_a_valid;
            r_c_valid    <= r_b_valid;
            r_d_valid[0] <= r_c_valid;
            for (int k = 1; k < LAT; k++) begin
                r_d_valid[k] <= r_d_valid[k-1];
            end
            r_out_valid  <= r_d_valid[LAT-1];
        end
    end

    // stage a
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_op <= i_s_axis_tuser;
            r_a_rr <= PW'(w_ar * w_br);
            r_a_ii <= PW'(w_ai * w_bi);
            r_a_ri <= PW'(w_ar * w_bi);
            r_a_ir <= PW'(w_ai * w_br);
            r_a_bb <= PW'(w_br * w_br);
            r_a_cc <= PW'(w_bi * w_bi);
            if (i_s_axis_tuser == cau_pkg::OP_SUB) begin
                r_a_as_re <= (WIDTH+1)'(w_ar) - (WIDTH+1)'(w_br);
                r_a_as_im <= (WIDTH+1)'(w_ai) - (WIDTH+1)'(w_bi);
            end else begin
                r_a_as_re <= (WIDTH+1)'(w_ar) + (WIDTH+1)'(w_br);
                r_a_as_im <= (WIDTH+1)'(w_ai) + (WIDTH+1)'(w_bi);
            end
        end
    end

    // stage b
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_b_op  <= r_a_op;
            r_b_den <= r_a_bb + r_a_cc;
            case (r_a_op)
                cau_pkg::OP_MUL: begin
                    r_b_re <= (PW+1)'(r_a_rr) - (PW+1)'(r_a_ii);
                    r_b_im <= (PW+1)'(r_a_ri) + (PW+1)'(r_a_ir);
                end
                cau_pkg::OP_DIV: begin
                    r_b_re <= (PW+1)'(r_a_rr) + (PW+1)'(r_a_ii);
                    r_b_im <= (PW+1)'(r_a_ir) - (PW+1)'(r_a_ri);
                end
                default: begin
                    r_b_re <= (PW+1)'(r_a_as_re);
                    r_b_im <= (PW+1)'(r_a_as_im);
                end
            endcase
        end
    end

    // stage c
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_c_op     <= r_b_op;
            r_c_den    <= r_b_den;
            r_c_dz     <= (r_b_op == cau_pkg::OP_DIV) && (r_b_den == '0);
            r_c_neg_re <= r_b_re[PW];
            r_c_neg_im <= r_b_im[PW];
            r_c_mag_re <= r_b_re[PW] ? PW'(-r_b_re) : r_b_re[PW-1:0];
            r_c_mag_im <= r_b_im[PW] ? PW'(-r_b_im) : r_b_im[PW-1:0];
        end
    end

    // side line, product rounding on entry
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_d_op[0]     <= r_c_op;
            r_d_dz[0]     <= r_c_dz;
            r_d_neg_re[0] <= r_c_neg_re;
            r_d_neg_im[0] <= r_c_neg_im;
            if (r_c_op == cau_pkg::OP_MUL) begin
                r_d_mag_re[0] <= (r_c_mag_re + HALF_LSB) >> FRAC_BITS;
                r_d_mag_im[0] <= (r_c_mag_im + HALF_LSB) >> FRAC_BITS;
            end else begin
                r_d_mag_re[0] <= r_c_mag_re;
                r_d_mag_im[0] <= r_c_mag_im;
            end
            for (int k = 1; k < LAT; k++) begin
                r_d_op[k]     <= r_d_op[k-1];
                r_d_dz[k]     <= r_d_dz[k-1];
                r_d_neg_re[k] <= r_d_neg_re[k-1];
                r_d_neg_im[k] <= r_d_neg_im[k-1];
                r_d_mag_re[k] <= r_d_mag_re[k-1];
                r_d_mag_im[k] <= r_d_mag_im[k-1];
            end
        end
    end

    cau_divider #(
        .WIDTH     (WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_num_re (r_c_mag_re),
        .i_num_im (r_c_mag_im),
        .i_den    (r_c_den),
        .o_quo_re (w_quo_re),
        .o_quo_im (w_quo_im),
        .o_ovf_re (w_ovf_re),
        .o_ovf_im (w_ovf_im)
    );

    // quotient rounding: half of the doubled quotient, rounded up
    always_comb begin
        logic [NQ:0] v_qr;
        logic [NQ:0] v_qi;
        v_qr = ({1'b0, w_quo_re} + (NQ+1)'(1)) >> 1;
        v_qi = ({1'b0, w_quo_im} + (NQ+1)'(1)) >> 1;
        if (r_d_op[LAT-1] == cau_pkg::OP_DIV) begin
            w_f_mag_re = w_ovf_re ? '1 : PW'(v_qr);
            w_f_mag_im = w_ovf_im ? '1 : PW'(v_qi);
        end else begin
            w_f_mag_re = r_d_mag_re[LAT-1];
            w_f_mag_im = r_d_mag_im[LAT-1];
        end
    end

    // saturation to the field range
    always_comb begin
        if (r_d_neg_re[LAT-1]) begin
            n_sat_re = w_f_mag_re > HALF_RNG;
            n_res_re = n_sat_re ? HALF_RNG[WIDTH-1:0] : WIDTH'(-w_f_mag_re);
        end else begin
            n_sat_re = w_f_mag_re > (HALF_RNG - PW'(1));
            n_res_re = n_sat_re ? WIDTH'(HALF_RNG - PW'(1)) : w_f_mag_re[WIDTH-1:0];
        end
        if (r_d_neg_im[LAT-1]) begin
            n_sat_im = w_f_mag_im > HALF_RNG;
            n_res_im = n_sat_im ? HALF_RNG[WIDTH-1:0] : WIDTH'(-w_f_mag_im);
        end else begin
            n_sat_im = w_f_mag_im > (HALF_RNG - PW'(1));
            n_res_im = n_sat_im ? WIDTH'(HALF_RNG - PW'(1)) : w_f_mag_im[WIDTH-1:0];
        end
    end

    // output register, zero result on a zero divisor
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            if (r_d_dz[LAT-1]) begin
                r_res_re <= '0;
                r_res_im <= '0;
                r_sat    <= 1'b0;
                r_dz     <= 1'b1;
            end else begin
                r_res_re <= n_res_re;
                r_res_im <= n_res_im;
                r_sat    <= n_sat_re || n_sat_im;
                r_dz     <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_res_im, r_res_re});
    assign o_m_axis_tuser  = {r_dz, r_sat};

endmodule

// File: dv/complex_arithmetic_unit_tb.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;

    localparam int W  = cau_pkg::DEF_WIDTH;
    localparam int FB = cau_pkg::DEF_FRAC_BITS;
    localparam longint unsigned HALF = 64'd1 << (W - 1);
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]          op;
        logic signed [W-1:0] ar, ai, br, bi;
        bit                  drain;
    } t_operands;

    typedef struct {
        logic [W-1:0] re, im;
        logic         sat, dz;
    } t_cplx_res;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_axis_tvalid;
    logic                         o_s_axis_tready;
    logic [((4*W+7)/8)*8-1:0]     i_s_axis_tdata;   // a_re, a_im, b_re, b_im
    logic [cau_pkg::OP_W-1:0]     i_s_axis_tuser;   // opcode
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready;
    logic [((2*W+7)/8)*8-1:0]     o_m_axis_tdata;   // res_re, res_im
    logic [cau_pkg::FLAG_W-1:0]   o_m_axis_tuser;   // saturated, div_by_zero

    t_operands pending_ops[$];
    t_cplx_res expected_res[$];
    t_operands cur_op;
    int        send_gap, recv_stall, recv_hold, results_seen, idle_cycles, errors;
    bit        hold_done;

    complex_arithmetic_unit uut (.*);

    // clock
    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic longint unsigned mag_of(longint x);
        return x < 0 ? longint'(-x) : longint'(x);
    endfunction

    // exact signed sum as sign and magnitude
    function automatic longint unsigned add_sm(longint p, longint q, output bit neg);
        longint unsigned mp, mq;
        mp = mag_of(p);
        mq = mag_of(q);
        if ((p < 0) == (q < 0)) begin
            neg = p < 0;
            return mp + mq;
        end
        if (mp >= mq) begin
            neg = p < 0;
            return mp - mq;
        end
        neg = q < 0;
        return mq - mp;
    endfunction

    function automatic logic [W-1:0] clip(bit neg, longint unsigned mag, inout logic sat);
        if (neg) begin
            if (mag > HALF) begin
                sat = 1'b1;
                mag = HALF;
            end
            return W'(-mag);
        end
        if (mag > HALF - 1) begin
            sat = 1'b1;
            mag = HALF - 1;
        end
        return W'(mag);
    endfunction

    function automatic longint unsigned round_frac(longint unsigned mag);
        if (FB == 0) return mag;
        return (mag + (64'd1 << (FB - 1))) >> FB;
    endfunction

    // magnitude * 2^FB / den, rounded half away from zero
    function automatic longint unsigned frac_quot(longint unsigned mag, longint unsigned den);
        longint unsigned q, r;
        q = mag / den;
        r = mag % den;
        if (q > (64'd1 << W)) return 64'd1 << W;
        for (int i = 0; i < FB; i++) begin
            q = q << 1;
            if (r >= den - r) begin
                r = r - (den - r);
                q = q + 1;
            end else begin
                r = r << 1;
            end
        end
        if (r >= den - r) q = q + 1;
        return q;
    endfunction

    function automatic t_cplx_res cplx_compute(t_operands o);
        t_cplx_res       res;
        longint          ar, ai, br, bi;
        longint unsigned mr, mi, den;
        bit              nr, ni;
        ar = o.ar; ai = o.ai; br = o.br; bi = o.bi;
        nr = 0; ni = 0; mr = 0; mi = 0;
        res.sat = 0;
        res.dz  = 0;
        case (o.op)
            cau_pkg::OP_ADD: begin
                mr = add_sm(ar, br, nr);
                mi = add_sm(ai, bi, ni);
            end
            cau_pkg::OP_SUB: begin
                mr = add_sm(ar, -br, nr);
                mi = add_sm(ai, -bi, ni);
            end
            cau_pkg::OP_MUL: begin
                mr = round_frac(add_sm(ar * br, -(ai * bi), nr));
                mi = round_frac(add_sm(ar * bi, ai * br, ni));
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    res.dz = 1;
                end else begin
                    mr = frac_quot(add_sm(ar * br, ai * bi, nr), den);
                    mi = frac_quot(add_sm(ai * br, -(ar * bi), ni), den);
                end
            end
        endcase
        res.re = clip(nr, mr, res.sat);
        res.im = clip(ni, mi, res.sat);
        return res;
    endfunction

    // mostly short gaps, some long ones, runs with none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [W-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return $signed(16'($urandom_range(0, 1200))) - 16'sd600;
            2: return $signed(16'($urandom_range(0, 16))) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_op(logic [1:0] op, logic signed [W-1:0] ar, ai, br, bi,
                            bit drain = 0);
        t_operands o;
        o.op = op; o.ar = ar; o.ai = ai; o.br = br; o.bi = bi; o.drain = drain;
        pending_ops.push_back(o);
    endtask

    // sender: presents queued items, records expected results on each transfer
    always @(posedge i_clk) begin
        bit busy, nv;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            busy = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_res.push_back(cplx_compute(cur_op));
                busy = 0;
            end
            nv = busy;
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].drain && expected_res.size() > 0)) begin
                    cur_op = pending_ops.pop_front();
                    i_s_axis_tdata <= {cur_op.bi, cur_op.br, cur_op.ai, cur_op.ar};
                    i_s_axis_tuser <= cur_op.op;
                    nv = 1;
                    send_gap = pick_gap();
                end
            end
            i_s_axis_tvalid <= nv;
        end
    end

    // receiver: random stalls plus one long hold-off to back up the pipeline
    always @(posedge i_clk) begin
        bit rdy;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (!hold_done && results_seen >= 600) begin
                hold_done = 1;
                recv_hold = 400;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                rdy = 0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                rdy = 0;
            end else begin
                rdy = 1;
                recv_stall = pick_gap();
            end
            i_m_axis_tready <= rdy;
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_cplx_res exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_res.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                exp_r = expected_res.pop_front();
                if (o_m_axis_tdata[W-1:0] !== exp_r.re) begin
                    $error("res_re expected %0d got %0d", $signed(exp_r.re),
                           $signed(o_m_axis_tdata[W-1:0]));
                    errors++;
                end
                if (o_m_axis_tdata[2*W-1:W] !== exp_r.im) begin
                    $error("res_im expected %0d got %0d", $signed(exp_r.im),
                           $signed(o_m_axis_tdata[2*W-1:W]));
                    errors++;
                end
                if (o_m_axis_tuser[0] !== exp_r.sat) begin
                    $error("saturated expected %0d got %0d", exp_r.sat, o_m_axis_tuser[0]);
                    errors++;
                end
                if (o_m_axis_tuser[1] !== exp_r.dz) begin
                    $error("div_by_zero expected %0d got %0d", exp_r.dz, o_m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [1:0] op;
        logic signed [W-1:0] br, bi;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        send_gap = 0; recv_stall = 0; recv_hold = 0;
        results_seen = 0; idle_cycles = 0; errors = 0; hold_done = 0;

        // directed: extremes, every opcode, divide by zero, tiny divisors
        queue_op(cau_pkg::OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        queue_op(cau_pkg::OP_ADD, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        queue_op(cau_pkg::OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        queue_op(cau_pkg::OP_SUB, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        queue_op(cau_pkg::OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        queue_op(cau_pkg::OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
        queue_op(cau_pkg::OP_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0);
        queue_op(cau_pkg::OP_MUL, 16'sd1, 16'sd0, 16'sd128, 16'sd0);
        queue_op(cau_pkg::OP_MUL, -16'sd1, 16'sd0, 16'sd128, 16'sd0);
        queue_op(cau_pkg::OP_DIV, 16'sd1000, -16'sd77, 16'sd0, 16'sd0);
        queue_op(cau_pkg::OP_DIV, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0);
        queue_op(cau_pkg::OP_DIV, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd0);
        queue_op(cau_pkg::OP_DIV, 16'sh8000, 16'sh7fff, 16'sd0, -16'sd1);
        queue_op(cau_pkg::OP_DIV, 16'sd256, 16'sd256, 16'sd256, 16'sd0);
        queue_op(cau_pkg::OP_DIV, 16'sd1, 16'sd0, 16'sd0, 16'sd512);
        queue_op(cau_pkg::OP_DIV, 16'sd1, 16'sd0, 16'sh8000, 16'sh8000);
        queue_op(cau_pkg::OP_DIV, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        queue_op(cau_pkg::OP_DIV, 16'sd3, 16'sd0, 16'sd3, 16'sd1, 1);

        // random, with a drained pause now and then
        for (int n = 0; n < 1950; n++) begin
            op = 2'($urandom);
            br = rand_val();
            bi = rand_val();
            if (op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
                br = 0;
                bi = 0;
            end
            queue_op(op, rand_val(), rand_val(), br, bi, n % 500 == 250);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !i_s_axis_tvalid && expected_res.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_res.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
